@@ design/agsu_pkg.sv @@
// agsu_pkg: word types and fixed codes for the sparse adagrad weight update engine
// no dependencies; used by adagrad_sparse_weight_update

package agsu_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_ACCUM  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_L2_STRENGTH   = 2'd1;
  localparam logic [1:0] CFG_ADAPTIVE_MODE = 2'd2;

  localparam int CFG_DATA_W = 31;
  localparam int SQSUM_W    = 48;

  // input word
  typedef struct packed {
    logic        [1:0]  action;
    logic        [11:0] entry_index;
    logic signed [31:0] activation;
    logic signed [31:0] error_term;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] weight_value;
    logic               was_updated;
  } out_word_t;

  // one table row: weight, gradient, square sum, touched mark
  typedef struct packed {
    logic signed [31:0]        weight;
    logic signed [31:0]        grad;
    logic [SQSUM_W-1:0]        sqsum;
    logic                      mark;
  } row_t;

endpackage

@@ design/adagrad_sparse_weight_update.sv @@
// adagrad_sparse_weight_update: sparse weight table trainer (sgd / adagrad with l2)
// depends on agsu_pkg; holds the table memory, the sequencer and the shared units
// An accepted word has its row read and dispatched: a read or unmarked update ends
// there, an accumulate writes gradient and mark, an update folds in l2, then takes
// the plain learning-rate step or (adaptive) the bit-serial root and the 62-step
// restoring divide on one shared compare-subtract unit. One word in flight at a time;
// the next word is taken as the result shows; a result waits while the last is held.
// Reset: synchronous, active low; afterwards a clearing pass writes every table
// row, during which no input word is taken.

module adagrad_sparse_weight_update #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  agsu_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output agsu_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [agsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int RS       = (agsu_pkg::SQSUM_W + FRACTION_BITS + 1) / 2;
  localparam int OP_W     = 2 * RS;
  localparam int SUB_W    = RS + 2;
  localparam int NUM_W    = 62;
  localparam int CNT_W    = 6;
  localparam int SQ_W     = agsu_pkg::SQSUM_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_L2    = 4'd5;
  localparam logic [3:0] S_SQM   = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_ADJ   = 4'd10;
  localparam logic [3:0] S_LRM   = 4'd11;
  localparam logic [3:0] S_STEP  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam logic [SQ_W-1:0]  SQ_MAX   = {SQ_W{1'b1}};
  localparam logic [SQ_W-1:0]  SQ_ONE   = SQ_W'(64'd1 << FRACTION_BITS);
  localparam logic [NUM_W-1:0] Q_LIMIT  = NUM_W'(64'd1 << 40);

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (!v[65] && (|v[64:31]))      r = 32'sh7fffffff;
    else if (v[65] && !(&v[64:31])) r = 32'sh80000000;
    else                            r = v[31:0];
    sat32 = r;
  endfunction

  // signed value from a scaled magnitude and a sign
  function automatic logic signed [65:0] apply_sign(input logic [63:0] m, input logic neg);
    logic signed [65:0] s;
    s = $signed({2'b00, m});
    apply_sign = neg ? -s : s;
  endfunction

  // registers
  logic [3:0]                 state_r, state_nxt;
  agsu_pkg::in_word_t         item_r, item_nxt;
  agsu_pkg::row_t             row_r;
  logic [63:0]                p_r, p_nxt;
  logic                       gneg_r, gneg_nxt;
  logic [31:0]                gmag_r, gmag_nxt;
  logic [SQ_W-1:0]            var_r, var_nxt;
  logic [OP_W-1:0]            opnd_r, opnd_nxt;
  logic [SUB_W-1:0]           rem_r, rem_nxt;
  logic [RS-1:0]              root_r, root_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [NUM_W-1:0]           quo_r, quo_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           clr_r, clr_nxt;
  agsu_pkg::out_word_t        res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  agsu_pkg::out_word_t        out_data_r, out_data_nxt;
  logic [30:0]                lr_r;
  logic [30:0]                l2_r;
  logic                       adapt_r;

  // table memory
  agsu_pkg::row_t             mem [TABLE_ENTRIES];
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, idx;
  agsu_pkg::row_t             mem_wdata;

  // shared multiplier and compare-subtract unit
  logic                       mul_en;
  logic [31:0]                mul_a, mul_b;
  logic [SUB_W-1:0]           sub_a, sub_b, sub_diff;
  logic                       sub_ge;
  logic [RS-1:0]              divisor;

  // arithmetic helpers
  logic [63:0]                p_sh;
  logic signed [31:0]         gsum, gl2, neww_plain, neww_ada;
  logic [64:0]                sq_sum;
  logic [SQ_W-1:0]            var_new;
  logic [40:0]                q_clamp;

  assign idx       = IDX_W'(item_r.entry_index);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign divisor   = (root_r == '0) ? RS'(1) : root_r;
  assign sub_diff  = sub_a - sub_b;
  assign sub_ge    = (sub_a >= sub_b);
  assign p_sh      = p_r >> FRACTION_BITS;

  // datapath values used by the finishing states
  assign gsum       = sat32(66'(row_r.grad) +
                            apply_sign(p_sh, item_r.activation[31] ^ item_r.error_term[31]));
  assign gl2        = sat32(66'(row_r.grad) - apply_sign(p_sh, row_r.weight[31]));
  assign neww_plain = sat32(66'(row_r.weight) + apply_sign(p_sh, gneg_r));
  assign sq_sum     = {17'd0, var_r} + 65'(p_sh);
  assign var_new    = (sq_sum > 65'(SQ_MAX)) ? SQ_MAX : sq_sum[SQ_W-1:0];
  assign q_clamp    = (quo_r > Q_LIMIT) ? 41'(Q_LIMIT) : quo_r[40:0];
  assign neww_ada   = sat32(66'(row_r.weight) + apply_sign(64'(q_clamp), gneg_r));

  // operand selection for the shared units
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    sub_a  = '0;
    sub_b  = '0;
    case (state_r)
      S_DISP: begin
        if (item_r.action == agsu_pkg::ACT_ACCUM) begin
          mul_en = 1'b1;
          mul_a  = mag32(item_r.activation);
          mul_b  = mag32(item_r.error_term);
        end else begin
          mul_en = (item_r.action == agsu_pkg::ACT_UPDATE) && row_r.mark;
          mul_a  = {1'b0, l2_r};
          mul_b  = mag32(row_r.weight);
        end
      end
      S_SQM: begin
        mul_en = 1'b1;
        mul_a  = gmag_r;
        mul_b  = gmag_r;
      end
      S_SQ, S_LRM: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, lr_r};
        mul_b  = gmag_r;
      end
      S_ROOT: begin
        sub_a = {rem_r[SUB_W-3:0], opnd_r[OP_W-1 -: 2]};
        sub_b = {root_r, 2'b01};
      end
      S_DIV: begin
        sub_a = {rem_r[SUB_W-2:0], num_r[NUM_W-1]};
        sub_b = SUB_W'(divisor);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    p_nxt         = mul_en ? (64'(mul_a) * 64'(mul_b)) : p_r;
    gneg_nxt      = gneg_r;
    gmag_nxt      = gmag_r;
    var_nxt       = var_r;
    opnd_nxt      = opnd_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx;
    mem_wdata     = row_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '{weight: '0, grad: '0, sqsum: SQ_ONE, mark: 1'b0};
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        res_nxt = '{weight_value: row_r.weight, was_updated: 1'b0};
        if (item_r.action == agsu_pkg::ACT_ACCUM) state_nxt = S_ACC;
        else if (mul_en)                          state_nxt = S_L2;
        else                                      state_nxt = S_DONE;
      end
      // gradient accumulate and mark
      S_ACC: begin
        mem_we         = 1'b1;
        mem_wdata.grad = gsum;
        mem_wdata.mark = 1'b1;
        state_nxt      = S_DONE;
      end
      // gradient with l2 decay folded in
      S_L2: begin
        gneg_nxt  = gl2[31];
        gmag_nxt  = mag32(gl2);
        var_nxt   = row_r.sqsum;
        state_nxt = adapt_r ? S_SQM : S_LRM;
      end
      S_SQM: state_nxt = S_SQ;
      // square sum update, root setup
      S_SQ: begin
        var_nxt   = var_new;
        opnd_nxt  = OP_W'(var_new) << FRACTION_BITS;
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      // one root bit per cycle
      S_ROOT: begin
        rem_nxt  = sub_ge ? sub_diff : sub_a;
        root_nxt = {root_r[RS-2:0], sub_ge};
        opnd_nxt = opnd_r << 2;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RS - 1)) begin
          rem_nxt   = '0;
          num_nxt   = p_r[NUM_W-1:0];
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt = sub_ge ? sub_diff : sub_a;
        quo_nxt = {quo_r[NUM_W-2:0], sub_ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = S_ADJ;
      end
      S_ADJ: begin
        mem_we    = 1'b1;
        mem_wdata = '{weight: neww_ada, grad: '0, sqsum: var_r, mark: 1'b0};
        res_nxt   = '{weight_value: neww_ada, was_updated: 1'b1};
        state_nxt = S_DONE;
      end
      S_LRM: state_nxt = S_STEP;
      S_STEP: begin
        mem_we    = 1'b1;
        mem_wdata = '{weight: neww_plain, grad: '0, sqsum: row_r.sqsum, mark: 1'b0};
        res_nxt   = '{weight_value: neww_plain, was_updated: 1'b1};
        state_nxt = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= 31'd6554;
      l2_r    <= '0;
      adapt_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        agsu_pkg::CFG_LEARNING_RATE: lr_r    <= cfg_wdata;
        agsu_pkg::CFG_L2_STRENGTH:   l2_r    <= cfg_wdata;
        agsu_pkg::CFG_ADAPTIVE_MODE: adapt_r <= cfg_wdata[0];
        default:                     adapt_r <= adapt_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    p_r        <= p_nxt;
    gneg_r     <= gneg_nxt;
    gmag_r     <= gmag_nxt;
    var_r      <= var_nxt;
    opnd_r     <= opnd_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) row_r <= mem[idx];
  end

`ifndef SYNTHESIS
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing a word");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("table written outside a work state");

  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (cnt_r < CNT_W'(RS)))
    else $error("root step count out of range");
`endif

endmodule

@@ tb/adagrad_sparse_weight_update_tb.sv @@
// adagrad_sparse_weight_update_tb: self-checking bench for the sparse adagrad weight trainer
// depends on agsu_pkg and adagrad_sparse_weight_update; keeps its own copy of the weight table
`timescale 1ns / 1ps

module adagrad_sparse_weight_update_tb;

  localparam int ENTRIES = 4096;
  localparam int FBITS   = 16;
  localparam logic [47:0] SQ_MAX = 48'hFFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  agsu_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  agsu_pkg::out_word_t out_data;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [agsu_pkg::CFG_DATA_W-1:0] cfg_wdata;

  adagrad_sparse_weight_update u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the trainer state
  logic signed [31:0] shadow_weight [ENTRIES];
  logic signed [31:0] shadow_grad [ENTRIES];
  logic [47:0] shadow_sqsum [ENTRIES];
  logic shadow_mark [ENTRIES];
  logic [30:0] lr_reg;
  logic [30:0] l2_reg;
  logic adapt_reg;

  agsu_pkg::out_word_t pending_weights[$];
  int err_count;
  int words_sent;
  int results_seen;
  int updates_seen;
  bit hold_off;     // receiver long stall request
  bit rand_stall;   // receiver random stall enable

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] abs_val(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // product scaled by 2^-F, truncated toward zero
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [63:0] p;
    p = (abs_val(a) * abs_val(b)) >> FBITS;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  // floor of sqrt(v * 2^F), bit by bit
  function automatic logic [63:0] scaled_root(input logic [47:0] v);
    logic [79:0] opnd;
    logic [81:0] rem;
    logic [81:0] trial;
    logic [63:0] r;
    opnd = {32'd0, v} << FBITS;
    rem = 0;
    r = 0;
    for (int i = 39; i >= 0; i--) begin
      rem = (rem << 2) | opnd[2*i +: 2];
      trial = ({18'd0, r} << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // apply one word to the shadow state, return the expected result
  function automatic agsu_pkg::out_word_t train_step(input agsu_pkg::in_word_t w);
    agsu_pkg::out_word_t res;
    int idx;
    logic signed [63:0] wt, gl2, delta;
    logic [63:0] sq, var_s, rt, q, m;
    idx = w.entry_index;
    res.was_updated = 1'b0;
    if (w.action == agsu_pkg::ACT_ACCUM) begin
      shadow_grad[idx] = 32'(sat_word(64'(shadow_grad[idx]) +
                                      fx_mul(w.activation, w.error_term)));
      shadow_mark[idx] = 1'b1;
    end else if (w.action == agsu_pkg::ACT_UPDATE && shadow_mark[idx]) begin
      wt = shadow_weight[idx];
      gl2 = sat_word(64'(shadow_grad[idx]) - fx_mul($signed({33'd0, l2_reg}), wt));
      if (adapt_reg) begin
        m = abs_val(gl2);
        sq = (m * m) >> FBITS;
        var_s = 64'(shadow_sqsum[idx]);
        var_s = (sq > 64'(SQ_MAX) - var_s) ? 64'(SQ_MAX) : var_s + sq;
        shadow_sqsum[idx] = var_s[47:0];
        rt = scaled_root(var_s[47:0]);
        if (rt == 0) rt = 1;
        q = (64'(lr_reg) * m) / rt;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        delta = gl2 < 0 ? -$signed(q) : $signed(q);
      end else begin
        delta = fx_mul($signed({33'd0, lr_reg}), gl2);
      end
      shadow_weight[idx] = 32'(sat_word(wt + delta));
      shadow_grad[idx] = 0;
      shadow_mark[idx] = 1'b0;
      res.was_updated = 1'b1;
    end
    res.weight_value = shadow_weight[idx];
    return res;
  endfunction

  // receiver: idle a drawn number of cycles per word, or hold off on request
  initial begin
    int wait_cycles;
    bit taken;
    out_ready = 1'b0;
    forever begin
      wait_cycles = rand_stall ? $urandom_range(0, 10) : 0;
      repeat (wait_cycles) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        out_ready <= !hold_off;
        @(posedge clk);
        taken = out_valid && out_ready;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.was_updated) updates_seen++;
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result weight=%h upd=%b", $time,
                 out_data.weight_value, out_data.was_updated);
        err_count++;
      end else begin
        agsu_pkg::out_word_t exp_w;
        exp_w = pending_weights.pop_front();
        if (exp_w.weight_value !== out_data.weight_value)
          begin
          $display("%0t: weight mismatch expected %h actual %h", $time,
                   exp_w.weight_value, out_data.weight_value);
          err_count++;
        end
        if (exp_w.was_updated !== out_data.was_updated) begin
          $display("%0t: was_updated mismatch expected %b actual %b", $time,
                   exp_w.was_updated, out_data.was_updated);
          err_count++;
        end
      end
    end
  end

  // send one word after a random gap, predict at acceptance
  task automatic send_word(input agsu_pkg::in_word_t w, input bit gap = 1'b1);
    int pause;
    pause = gap ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_weights = {pending_weights, train_step(w)};
    words_sent++;
  endtask

  // stop offering words
  task automatic idle_input;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic agsu_pkg::in_word_t make_word(input logic [1:0] act,
                                                   input logic [11:0] idx,
                                                   input logic [31:0] a,
                                                   input logic [31:0] e);
    agsu_pkg::in_word_t w;
    w.action = act;
    w.entry_index = idx;
    w.activation = a;
    w.error_term = e;
    return w;
  endfunction

  // wait for every expected result plus the longest latency
  task automatic drain;
    int guard;
    guard = 0;
    idle_input();
    while (pending_weights.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == agsu_pkg::CFG_LEARNING_RATE) lr_reg = val;
    else if (addr == agsu_pkg::CFG_L2_STRENGTH) l2_reg = val;
    else adapt_reg = val[0];
  endtask

  function automatic logic [31:0] rand_fix(input int narrow);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return narrow ? $signed($urandom_range(0, 262143)) - 131072 : $urandom;
    endcase
  endfunction

  // directed: field extremes, every action and the special cases
  task automatic test_directed;
    send_word(make_word(agsu_pkg::ACT_READ, 12'd0, 0, 0));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'd5, 0, 0));   // update on unmarked entry
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'd5, 32'h0001_0000, 32'h0002_0000));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'd5, 0, 0));
    send_word(make_word(agsu_pkg::ACT_READ, 12'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(agsu_pkg::ACT_SPARE, 12'd5, 0, 0));    // unused action acts as read
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'hFFF, 32'h8000_0000, 32'h8000_0000));
    // saturating grad
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'hFFF, 0, 0));
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'hAAA, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'hAAA, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'hAAA, 0, 0));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'hAAA, 0, 0));
    send_word(make_word(agsu_pkg::ACT_ACCUM, 12'h555, 32'hFFFF_0000, 32'h0003_0000));
    send_word(make_word(agsu_pkg::ACT_READ, 12'h555, 0, 0));
    send_word(make_word(agsu_pkg::ACT_UPDATE, 12'h555, 0, 0));
    drain();
  endtask

  // random mix over a small working set so updates find marked entries
  task automatic test_random_mix(input int count, input int narrow);
    logic [1:0] act;
    logic [11:0] idx;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      act = r < 50 ? agsu_pkg::ACT_ACCUM : r < 85 ? agsu_pkg::ACT_UPDATE :
            r < 95 ? agsu_pkg::ACT_READ : agsu_pkg::ACT_SPARE;
      idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
      send_word(make_word(act, idx, rand_fix(narrow), rand_fix(narrow)),
                $urandom_range(0, 4) != 0);
    end
    idle_input();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      test_random_mix(20, 1);
    join
    drain();
  endtask

  initial begin
    int sets;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = agsu_pkg::CFG_LEARNING_RATE;
    cfg_wdata = '0;
    hold_off = 1'b0;
    rand_stall = 1'b0;
    err_count = 0;
    words_sent = 0;
    results_seen = 0;
    updates_seen = 0;
    lr_reg = 31'd6554;
    l2_reg = 31'd0;
    adapt_reg = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_weight[i] = 0;
      shadow_grad[i] = 0;
      shadow_sqsum[i] = 48'd1 << FBITS;
      shadow_mark[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    rand_stall = 1'b1;
    test_backpressure();

    // several register settings, extremes included
    for (sets = 0; sets < 8; sets++) begin
      case (sets)
        0: begin write_reg(agsu_pkg::CFG_LEARNING_RATE, 31'd6554);
                 write_reg(agsu_pkg::CFG_L2_STRENGTH, 31'd0);
                 write_reg(agsu_pkg::CFG_ADAPTIVE_MODE, 31'd1); end
        1: begin write_reg(agsu_pkg::CFG_LEARNING_RATE, 31'h7FFF_FFFF);
                 write_reg(agsu_pkg::CFG_L2_STRENGTH, 31'h7FFF_FFFF);
                 write_reg(agsu_pkg::CFG_ADAPTIVE_MODE, 31'd0); end
        2: begin write_reg(agsu_pkg::CFG_LEARNING_RATE, 31'd0);
                 write_reg(agsu_pkg::CFG_ADAPTIVE_MODE, 31'd1); end
        3: begin write_reg(agsu_pkg::CFG_LEARNING_RATE, 31'h7FFF_FFFF);
                 write_reg(agsu_pkg::CFG_L2_STRENGTH, 31'd0); end
        default: begin
          write_reg(agsu_pkg::CFG_LEARNING_RATE, 31'($urandom_range(0, 32'h7FFF_FFFF)));
          write_reg(agsu_pkg::CFG_L2_STRENGTH, 31'($urandom_range(0, 32'h0004_0000)));
          write_reg(agsu_pkg::CFG_ADAPTIVE_MODE, 31'($urandom_range(0, 1)));
        end
      endcase
      test_random_mix(160, sets % 2);
      if (sets == 4) begin
        rand_stall = 1'b0;  // a stretch with no receiver stalls
      end else begin
        rand_stall = 1'b1;
      end
      drain();              // sender pauses until all results are back
    end

    drain();
    $display("sent %0d words, checked %0d results, %0d applied updates", words_sent,
             results_seen, updates_seen);
    $display("covered all actions, sgd and adagrad modes, register extremes, back-pressure");
    if (err_count == 0 && pending_weights.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_weights.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_weights.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
